FILE: hdl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg: shared types and codes for the slot pool allocator
// Request layout, request modes and result status codes used by the
// allocator core and its free stack memory.
// ----------------------------------------------------------------------------
package spa_pkg;

  // Width of a slot index as carried on the ports and stored on the stack.
  localparam int SLOT_IDX_W = 8;

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_RANGE  = 2'd2;
  localparam logic [1:0] STATUS_DOUBLE = 2'd3;

  // One captured request.
  typedef struct packed {
    logic                  mode;
    logic [SLOT_IDX_W-1:0] slot_index;
  } req_t;

endpackage

FILE: hdl/spa_stack_ram.sv
// ----------------------------------------------------------------------------
// spa_stack_ram: free stack storage with a registered top-of-stack read
// One write port and one registered read port; a write to the address being
// read in the same cycle is forwarded into the read register.
// ----------------------------------------------------------------------------
module spa_stack_ram #(
  parameter int DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  logic [spa_pkg::SLOT_IDX_W-1:0]  wr_data,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr,
  output logic [spa_pkg::SLOT_IDX_W-1:0]  rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [spa_pkg::SLOT_IDX_W-1:0] mem [DEPTH];
  logic [spa_pkg::SLOT_IDX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The read register always follows the entry the next pop will need.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr[AW-1:0])) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/slot_pool_allocator.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator: fixed pool slot allocator with a LIFO free list
// Allocates from recently freed slots first, then from a bump counter, and
// validates frees against the high-water mark and per-slot occupied bits.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request is captured in the input register, and its
// decision is registered in the result register that drives the out_ ports.
// Throughput: one request per cycle once busy is low; busy clears at the first
// edge that samples rst_n high, and the receiver cannot stall, so results keep pace.
// Reset: rst_n is synchronous and active low; it empties the free stack, zeroes
// the high-water mark and clears all occupied bits.
// ----------------------------------------------------------------------------
module slot_pool_allocator #(
  parameter int SLOTS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_mode,
  input  logic [spa_pkg::SLOT_IDX_W-1:0]  in_slot_index,
  output logic                            out_valid,
  output logic [spa_pkg::SLOT_IDX_W-1:0]  out_granted_slot,
  output logic [1:0]                      out_status
);

  // Counter width holds every value from 0 to SLOTS inclusive.
  localparam int CW = $clog2(SLOTS + 1);
  // Stack address width.
  localparam int AW = $clog2(SLOTS);
  // Only slots that an 8-bit index can name can ever be freed, so only those
  // need an occupied bit.
  localparam int BUSY_N = (SLOTS < 256) ? SLOTS : 256;
  localparam int BW = $clog2(BUSY_N);
  // Common width for comparing a request index with the high-water mark.
  localparam int MW = (CW > spa_pkg::SLOT_IDX_W) ? CW : spa_pkg::SLOT_IDX_W;

  // Handshake and input register.
  logic           busy_r;
  logic           req_vld_r;
  spa_pkg::req_t  req_r;

  // Allocator state.
  logic [CW-1:0]     hw_r, hw_nxt;
  logic [CW-1:0]     depth_r, depth_nxt;
  logic [BUSY_N-1:0] slot_busy_r, slot_busy_nxt;

  // Result register.
  logic                           out_valid_r;
  logic [spa_pkg::SLOT_IDX_W-1:0] out_slot_r, out_slot_nxt;
  logic [1:0]                     out_status_r, out_status_nxt;

  // Free stack interface.
  logic                           stk_wr_en;
  logic [AW-1:0]                  stk_wr_addr;
  logic [AW-1:0]                  stk_rd_addr;
  logic [spa_pkg::SLOT_IDX_W-1:0] stk_top;

  logic accept;

  // Busy is high during reset and clears at the first edge that samples rst_n
  // high; afterwards every cycle can take a request.
  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      req_vld_r <= 1'b0;
    end else begin
      busy_r    <= 1'b0;
      req_vld_r <= accept;
    end
  end

  // The request payload needs no reset; it is qualified by req_vld_r.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.mode       <= in_mode;
      req_r.slot_index <= in_slot_index;
    end
  end

  // The whole decision for one request is taken here in one pass. The stack
  // top is already sitting in the memory read register, so a pop needs no
  // separate read, and the next read address is steered from the new depth.
  always_comb begin
    hw_nxt         = hw_r;
    depth_nxt      = depth_r;
    slot_busy_nxt  = slot_busy_r;
    stk_wr_en      = 1'b0;
    out_slot_nxt   = '0;
    out_status_nxt = spa_pkg::STATUS_OK;

    if (req_vld_r) begin
      if (req_r.mode == spa_pkg::MODE_ALLOC) begin
        if (depth_r != '0) begin
          // Reuse the most recently freed slot.
          depth_nxt    = depth_r - CW'(1);
          out_slot_nxt = stk_top;
          if ({1'b0, stk_top} < 9'(BUSY_N)) begin
            slot_busy_nxt[stk_top[BW-1:0]] = 1'b1;
          end
        end else if (hw_r < CW'(SLOTS)) begin
          // Hand out a slot that has never been used.
          hw_nxt       = hw_r + CW'(1);
          out_slot_nxt = spa_pkg::SLOT_IDX_W'(hw_r);
          if (hw_r < CW'(BUSY_N)) begin
            slot_busy_nxt[hw_r[BW-1:0]] = 1'b1;
          end
        end else begin
          // Pool is exhausted: nothing changes.
          out_status_nxt = spa_pkg::STATUS_FULL;
        end
      end else begin
        out_slot_nxt = req_r.slot_index;
        if (MW'(req_r.slot_index) >= MW'(hw_r)) begin
          // The slot was never handed out.
          out_status_nxt = spa_pkg::STATUS_RANGE;
        end else if (!slot_busy_r[req_r.slot_index[BW-1:0]]) begin
          // The slot is already free; pushing it again would duplicate it.
          out_status_nxt = spa_pkg::STATUS_DOUBLE;
        end else begin
          slot_busy_nxt[req_r.slot_index[BW-1:0]] = 1'b0;
          if (depth_r < CW'(SLOTS)) begin
            stk_wr_en = 1'b1;
            depth_nxt = depth_r + CW'(1);
          end
        end
      end
    end
  end

  assign stk_wr_addr = depth_r[AW-1:0];
  // After this request the top of stack lives one below the new depth.
  assign stk_rd_addr = AW'(depth_nxt - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r        <= '0;
      depth_r     <= '0;
      slot_busy_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hw_r        <= hw_nxt;
      depth_r     <= depth_nxt;
      slot_busy_r <= slot_busy_nxt;
      out_valid_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  spa_stack_ram #(
    .DEPTH (SLOTS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (req_r.slot_index),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_top)
  );

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_status_r;

endmodule

FILE: test/slot_pool_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_allocator_tb: self-checking bench for the slot pool allocator
// Drives allocate and free requests through the start/busy handshake and
// predicts every grant from a behavioral copy of the pool. That copy holds the
// bump counter, the LIFO free stack and the occupied bits. Each strobed
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module slot_pool_allocator_tb;

  localparam int SLOTS = 256;
  localparam int IW    = spa_pkg::SLOT_IDX_W;

  // One predicted or observed result.
  typedef struct packed {
    logic [IW-1:0] slot;
    logic [1:0]    status;
  } grant_t;

  // Behavioral copy of the pool together with the queue of grants that are
  // still to come out of the block. Requests are recorded in the order the
  // block accepts them, and grants are checked in the same order.
  class slot_grant_board;
    int unsigned bump_mark;
    int unsigned stack_fill;
    int unsigned free_stack [SLOTS];
    bit          occupied [SLOTS];
    grant_t      pending_grants [$];
    int unsigned mismatches;
    int unsigned failures;

    // Updates the pool copy for one accepted request and returns its grant.
    function grant_t predict_grant(logic mode, logic [IW-1:0] idx);
      grant_t      g;
      int unsigned slot;
      g.slot   = idx;
      g.status = spa_pkg::STATUS_OK;
      if (mode == spa_pkg::MODE_ALLOC) begin
        if (stack_fill > 0) begin
          // The most recently freed slot goes out first.
          stack_fill--;
          slot = free_stack[stack_fill];
        end else if (bump_mark < SLOTS) begin
          slot = bump_mark;
          bump_mark++;
        end else begin
          g.slot   = '0;
          g.status = spa_pkg::STATUS_FULL;
          return g;
        end
        occupied[slot] = 1'b1;
        g.slot = slot[IW-1:0];
      end else if (int'(idx) >= int'(bump_mark)) begin
        g.status = spa_pkg::STATUS_RANGE;
      end else if (!occupied[idx]) begin
        g.status = spa_pkg::STATUS_DOUBLE;
      end else begin
        occupied[idx] = 1'b0;
        free_stack[stack_fill] = int'(idx);
        stack_fill++;
      end
      return g;
    endfunction

    function void note_request(logic mode, logic [IW-1:0] idx);
      pending_grants.push_back(predict_grant(mode, idx));
    endfunction

    function void check_grant(logic [IW-1:0] slot, logic [1:0] status);
      grant_t want;
      if (pending_grants.size() == 0) begin
        failures++;
        if (mismatches < 10)
          $display("mismatch: grant slot=%0d status=%0d with no request pending",
                   slot, status);
        mismatches++;
        return;
      end
      want = pending_grants.pop_front();
      if (slot !== want.slot || status !== want.status) begin
        failures++;
        if (mismatches < 10)
          $display("mismatch: slot exp=%0d got=%0d, status exp=%0d got=%0d",
                   want.slot, slot, want.status, status);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    // Picks a slot that is occupied right now, so that a free passes both
    // checks. Falls back to any index when nothing is occupied.
    function logic [IW-1:0] pick_occupied();
      int unsigned held [$];
      for (int i = 0; i < SLOTS; i++)
        if (occupied[i]) held.push_back(i);
      if (held.size() == 0) return IW'($urandom_range(255, 0));
      return IW'(held[$urandom_range(held.size() - 1, 0)]);
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          in_mode = spa_pkg::MODE_ALLOC;
  logic [IW-1:0] in_slot_index = '0;
  logic          busy;
  logic          out_valid;
  logic [IW-1:0] out_granted_slot;
  logic [1:0]    out_status;

  slot_grant_board board = new;

  slot_pool_allocator #(.SLOTS(SLOTS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_granted_slot(out_granted_slot),
    .out_status      (out_status)
  );

  // 4 ns clock period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Results cannot be held off, so every strobe is checked at the edge that
  // ends its cycle. Its request was recorded at the accept edge, ahead of both
  // registers, so order against the driver within one edge does not matter.
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_grant(out_granted_slot, out_status);
  end

  // Presents one request and holds it until the block takes it. Acceptance
  // is judged from the values seen at the edge, before this edge's updates.
  // The request is recorded in the same process, so the next pick of an
  // occupied slot already sees its effect.
  task automatic send_request(input logic mode, input logic [IW-1:0] idx);
    start         <= 1'b1;
    in_mode       <= mode;
    in_slot_index <= idx;
    do @(posedge clk); while (busy);
    board.note_request(mode, idx);
  endtask

  // Idle time between requests: mostly none, sometimes a short gap, now and then a
  // long one, so that pauses land on every phase of the two-stage pipeline.
  task automatic idle_gap(input bit burst);
    int unsigned roll;
    int unsigned cycles;
    roll   = $urandom_range(99, 0);
    cycles = 0;
    if (!burst) begin
      if (roll >= 90)      cycles = $urandom_range(30, 5);
      else if (roll >= 60) cycles = $urandom_range(3, 1);
    end
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Holds the sender off until every predicted grant has come back. It always
  // waits for an edge, so start is never lowered and raised in one step.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // One random request. alloc_pct sets the share of allocations, and
  // proper_pct the share of frees aimed at an occupied slot; the rest of the
  // frees take any index and so can hit the range and double-free paths.
  task automatic random_request(input int unsigned alloc_pct,
                                input int unsigned proper_pct, input bit burst);
    logic [IW-1:0] idx;
    if ($urandom_range(99, 0) < alloc_pct) begin
      // The index is ignored on allocate but still toggles on the port.
      send_request(spa_pkg::MODE_ALLOC, IW'($urandom_range(255, 0)));
    end else begin
      if ($urandom_range(99, 0) < proper_pct) idx = board.pick_occupied();
      else idx = IW'($urandom_range(255, 0));
      send_request(spa_pkg::MODE_FREE, idx);
    end
    idle_gap(burst);
  endtask

  // Run limit, far above the slowest correct run of this bench.
  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests on an empty pool first: with no slot handed out yet,
    // every free lies at or beyond the high-water mark, the lowest and the highest
    // index alike.
    send_request(spa_pkg::MODE_FREE, 8'd0);
    send_request(spa_pkg::MODE_FREE, 8'd255);
    // The bump counter hands out slots 0, 1 and 2 in order.
    send_request(spa_pkg::MODE_ALLOC, 8'd0);
    send_request(spa_pkg::MODE_ALLOC, 8'd0);
    send_request(spa_pkg::MODE_ALLOC, 8'd0);
    // A proper free, then the same slot again as a double free, then an index
    // just past the mark and the top index.
    send_request(spa_pkg::MODE_FREE, 8'd1);
    send_request(spa_pkg::MODE_FREE, 8'd1);
    send_request(spa_pkg::MODE_FREE, 8'd3);
    send_request(spa_pkg::MODE_FREE, 8'd255);
    // Slot 1 comes back from the free stack before the counter moves on.
    send_request(spa_pkg::MODE_ALLOC, 8'd0);
    // Two frees are popped in reverse order.
    send_request(spa_pkg::MODE_FREE, 8'd0);
    send_request(spa_pkg::MODE_FREE, 8'd2);
    send_request(spa_pkg::MODE_ALLOC, 8'd0);
    send_request(spa_pkg::MODE_ALLOC, 8'd0);
    // With the stack empty again the counter resumes at 3. The ignored index
    // field carries all ones here.
    send_request(spa_pkg::MODE_ALLOC, 8'd255);
    send_request(spa_pkg::MODE_ALLOC, 8'd0);
    // A double free of a slot below the mark that was never freed before.
    send_request(spa_pkg::MODE_FREE, 8'd4);
    send_request(spa_pkg::MODE_FREE, 8'd4);
    wait_drained();

    // Fill phase: mostly allocations, enough to exhaust the bump counter and
    // the free stack, so that the pool runs full and answers so repeatedly.
    for (int i = 0; i < 340; i++) random_request(95, 70, i < 40);
    wait_drained();

    // Drain phase: mostly frees of occupied slots, which fills the free stack
    // deep and later serves allocations from it in LIFO order.
    for (int i = 0; i < 330; i++) random_request(15, 85, i >= 150 && i < 200);
    wait_drained();

    // Mixed phase: allocations and frees in equal share, with back-to-back
    // stretches to keep the pipeline fully loaded.
    for (int i = 0; i < 520; i++) random_request(50, 75, (i % 130) < 30);

    // Let the last results come out, then keep the clock running so that any
    // stray strobe is still checked.
    wait_drained();
    repeat (8) @(posedge clk);
    if (board.pending() != 0) board.failures++;

    if (board.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: slot_pool_allocator.f
hdl/spa_pkg.sv
hdl/spa_stack_ram.sv
hdl/slot_pool_allocator.sv
test/slot_pool_allocator_tb.sv
